// ----- rtl/core/scfr_pkg.sv -----
// shared constants and types of the sum-checked frame receiver
package scfr_pkg;

    localparam logic [7:0] SYNC_BYTE   = 8'hAA;
    localparam int         STORE_DEPTH = 8;
    localparam int         IDX_W       = $clog2(STORE_DEPTH);
    localparam int         POS_W       = 9;

    // frame positions up to the start of the payload
    localparam logic [POS_W-1:0] POS_SYNC_SECOND = 9'd1;
    localparam logic [POS_W-1:0] POS_LENGTH      = 9'd2;
    localparam logic [POS_W-1:0] POS_PAYLOAD     = 9'd3;

    typedef struct packed {
        logic               frame_ok;
        logic [7:0]         payload_length;
        logic [15:0]        value_a;
        logic signed [15:0] value_b;
        logic signed [31:0] value_c;
    } result_t;

    // handshake between the input stage and the parser
    typedef struct packed {
        logic       step;
        logic [7:0] rx_byte;
    } step_t;

    typedef struct packed {
        logic at_checksum;
        logic load_result;
    } parser_status_t;

endpackage

// ----- rtl/core/scfr_frame_parser.sv -----
// frame position tracking, running sum, payload store and held values
module scfr_frame_parser (
    input  logic                    clk,
    input  logic                    rst_n,
    input  scfr_pkg::step_t         step_in,
    output scfr_pkg::parser_status_t status,
    output scfr_pkg::result_t       result
);
    import scfr_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       len_reg, len_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       store_reg [STORE_DEPTH];
    logic [7:0]       store_next [STORE_DEPTH];
    logic [15:0]      held_a_reg, held_a_next;
    logic [15:0]      held_b_reg, held_b_next;
    logic [31:0]      held_c_reg, held_c_next;

    logic [POS_W-1:0] checksum_pos;
    logic [POS_W-1:0] store_idx;
    logic             hunting;
    logic             at_length;
    logic             in_payload;
    logic             at_checksum;
    logic             sum_match;

    assign checksum_pos = {1'b0, len_reg} + POS_PAYLOAD;
    assign hunting      = (pos_reg < POS_LENGTH);
    assign at_length    = (pos_reg == POS_LENGTH);
    assign in_payload   = !hunting && !at_length && (pos_reg < checksum_pos);
    assign at_checksum  = !hunting && !at_length && !in_payload;
    assign store_idx    = pos_reg - POS_PAYLOAD;
    assign sum_match    = (sum_reg == step_in.rx_byte);

    always_comb
    begin
        pos_next    = pos_reg;
        len_next    = len_reg;
        sum_next    = sum_reg;
        held_a_next = held_a_reg;
        held_b_next = held_b_reg;
        held_c_next = held_c_reg;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            store_next[i] = store_reg[i];
        end
        if (step_in.step)
        begin
            if (hunting)
            begin
                pos_next = (step_in.rx_byte == SYNC_BYTE) ? pos_reg + 9'd1 : '0;
            end
            else if (at_length)
            begin
                len_next = step_in.rx_byte;
                sum_next = step_in.rx_byte;
                pos_next = POS_PAYLOAD;
            end
            else if (in_payload)
            begin
                // only the first entries are kept, the rest feed the sum
                for (int i = 0; i < STORE_DEPTH; i++)
                begin
                    if (store_idx == POS_W'(i))
                    begin
                        store_next[i] = step_in.rx_byte;
                    end
                end
                sum_next = sum_reg + step_in.rx_byte;
                pos_next = pos_reg + 9'd1;
            end
            else
            begin
                if (sum_match)
                begin
                    held_a_next = {store_reg[0], store_reg[1]};
                    held_b_next = {store_reg[2], store_reg[3]};
                    held_c_next = {store_reg[4], store_reg[5], store_reg[6], store_reg[7]};
                end
                pos_next = '0;
                sum_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            len_reg    <= '0;
            sum_reg    <= '0;
            held_a_reg <= '0;
            held_b_reg <= '0;
            held_c_reg <= '0;
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else
        begin
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            sum_reg    <= sum_next;
            held_a_reg <= held_a_next;
            held_b_reg <= held_b_next;
            held_c_reg <= held_c_next;
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                store_reg[i] <= store_next[i];
            end
        end
    end

    assign status.at_checksum = at_checksum;
    assign status.load_result = step_in.step && at_checksum;

    assign result.frame_ok       = sum_match;
    assign result.payload_length = len_reg;
    assign result.value_a        = held_a_next;
    assign result.value_b        = held_b_next;
    assign result.value_c        = held_c_next;

endmodule

// ----- rtl/core/scfr_result_reg.sv -----
// result register on the output channel
module scfr_result_reg (
    input  logic                     clk,
    input  logic                     rst_n,
    input  scfr_pkg::parser_status_t status,
    input  scfr_pkg::result_t        result_in,
    input  logic                     out_stall,
    output logic                     out_valid,
    output scfr_pkg::result_t        result_out
);
    import scfr_pkg::*;

    logic    valid_reg, valid_next;
    result_t result_reg;

    always_comb
    begin
        if (status.load_result)
        begin
            valid_next = 1'b1;
        end
        else
        begin
            valid_next = valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.load_result)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;

endmodule

// ----- rtl/core/sum_checked_frame_receiver.sv -----
// top level of the sum-checked frame receiver
// path: an accepted item waits in the input register and is parsed from there; a checksum
//   item's result is loaded into the result register when it is parsed
// throughput: one item per cycle; a checksum item waits in the input register only
//   while the result register holds an untaken result
// reset: asynchronous active-low rst_n hunts for the first sync byte and clears sum,
//   length, payload store and held values
module sum_checked_frame_receiver (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               frame_ok,
    output logic [7:0]         payload_length,
    output logic [15:0]        value_a,
    output logic signed [15:0] value_b,
    output logic signed [31:0] value_c
);
    import scfr_pkg::*;

    // input register: holds one item ahead of the parser
    logic           in_valid_reg, in_valid_next;
    logic [7:0]     byte_reg;
    logic           out_free;
    step_t          step_bus;
    parser_status_t status;
    result_t        parsed_result;
    result_t        shown_result;

    // the result slot is free if empty or being taken this cycle
    assign out_free = !out_valid || !out_stall;

    // only a checksum item needs room in the result register
    assign step_bus.step    = in_valid_reg && (!status.at_checksum || out_free);
    assign step_bus.rx_byte = byte_reg;

    // hold the input side while the buffered item cannot move on
    assign in_stall = in_valid_reg && !step_bus.step;

    always_comb
    begin
        if (in_stall)
        begin
            in_valid_next = in_valid_reg;
        end
        else
        begin
            in_valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= rx_byte;
        end
    end

    // position, sum, store and held values
    scfr_frame_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_in (step_bus),
        .status  (status),
        .result  (parsed_result)
    );

    // result register, loaded when a checksum item is parsed
    scfr_result_reg u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .status     (status),
        .result_in  (parsed_result),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .result_out (shown_result)
    );

    assign frame_ok       = shown_result.frame_ok;
    assign payload_length = shown_result.payload_length;
    assign value_a        = shown_result.value_a;
    assign value_b        = shown_result.value_b;
    assign value_c        = shown_result.value_c;

endmodule

// ----- tb/sum_checked_frame_receiver_tb.sv -----
// testbench of the sum-checked frame receiver: directed table, random frames, stall pressure
module sum_checked_frame_receiver_tb;
    import scfr_pkg::*;

    // generous ceiling: ~1900 bytes at ~0.7 items per cycle, one long hold-off, tail
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1900;
    localparam int DIR_ROWS     = 24;
    localparam int IDLE_PCT     = 27;
    localparam int TAIL_CYCLES  = 12;

    // one row of byte stimulus; typed rows carry a hand-written expected result
    typedef struct packed {
        logic [7:0] b;
        logic       typed;
        result_t    res;
    } stim_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         rx_byte = 8'h00;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               frame_ok;
    logic [7:0]         payload_length;
    logic [15:0]        value_a;
    logic signed [15:0] value_b;
    logic signed [31:0] value_c;

    sum_checked_frame_receiver uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .frame_ok       (frame_ok),
        .payload_length (payload_length),
        .value_a        (value_a),
        .value_b        (value_b),
        .value_c        (value_c)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // frame parser shadow: own copy of position, sum, store and held values
    // ------------------------------------------------------------------
    logic [POS_W-1:0] shadow_pos;
    logic [7:0]       shadow_len;
    logic [7:0]       shadow_sum;
    logic [7:0]       shadow_store [STORE_DEPTH];
    logic [15:0]      shadow_a;
    logic [15:0]      shadow_b;
    logic [31:0]      shadow_c;

    stim_t   byte_stream [$];     // bytes still to be offered, in order
    result_t expected_frames [$]; // frame results still owed by the block
    stim_t   dir_table [DIR_ROWS];
    stim_t   cur_row;             // row currently on the input port
    int      mismatches = 0;
    int      cycles = 0;
    logic    hold_off = 1'b0;
    logic    calm;

    // a stretch where neither side idles
    assign calm = (cycles >= 1500) && (cycles < 2100);

    function automatic result_t make_res(logic ok, logic [7:0] len, logic [15:0] a,
                                         logic [15:0] b, logic [31:0] c);
        result_t r;
        r.frame_ok       = ok;
        r.payload_length = len;
        r.value_a        = a;
        r.value_b        = b;
        r.value_c        = c;
        return r;
    endfunction

    function automatic stim_t plain(logic [7:0] b);
        stim_t s;
        s.b     = b;
        s.typed = 1'b0;
        s.res   = '0;
        return s;
    endfunction

    function automatic stim_t typed_row(logic [7:0] b, result_t res);
        stim_t s;
        s.b     = b;
        s.typed = 1'b1;
        s.res   = res;
        return s;
    endfunction

    task automatic shadow_reset();
        shadow_pos = '0;
        shadow_len = '0;
        shadow_sum = '0;
        shadow_a   = '0;
        shadow_b   = '0;
        shadow_c   = '0;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            shadow_store[i] = 8'h00;
        end
    endtask

    // advance the shadow parser by one byte; got is set when a frame ends
    task automatic parse_byte(input logic [7:0] b, output logic got, output result_t r);
        logic [POS_W-1:0] k;
        got = 1'b0;
        r   = '0;
        if (shadow_pos < POS_LENGTH)
        begin
            // sync hunt: any other byte drops back to the first sync byte
            shadow_pos = (b == SYNC_BYTE) ? shadow_pos + 1'b1 : '0;
        end
        else if (shadow_pos == POS_LENGTH)
        begin
            shadow_len = b;
            shadow_sum = b;
            shadow_pos = POS_PAYLOAD;
        end
        else if (shadow_pos < {1'b0, shadow_len} + POS_PAYLOAD)
        begin
            // payload beyond the store only feeds the sum
            k = shadow_pos - POS_PAYLOAD;
            if (k < STORE_DEPTH)
            begin
                shadow_store[k[IDX_W-1:0]] = b;
            end
            shadow_sum = shadow_sum + b;
            shadow_pos = shadow_pos + 1'b1;
        end
        else
        begin
            // checksum byte: held values move only on a match
            got = 1'b1;
            if (shadow_sum == b)
            begin
                shadow_a = {shadow_store[0], shadow_store[1]};
                shadow_b = {shadow_store[2], shadow_store[3]};
                shadow_c = {shadow_store[4], shadow_store[5], shadow_store[6], shadow_store[7]};
            end
            r = make_res(shadow_sum == b, shadow_len, shadow_a, shadow_b, shadow_c);
            shadow_pos = '0;
            shadow_sum = '0;
        end
    endtask

    // one random stretch of the stream: mostly whole frames, some noise and broken sync
    task automatic add_random_frame();
        int         kind;
        int         len;
        logic [7:0] sum;
        logic [7:0] pb;
        kind = $urandom_range(99);
        if (kind < 8)
        begin
            repeat ($urandom_range(4, 1)) byte_stream.push_back(plain(8'($urandom_range(255))));
        end
        else if (kind < 14)
        begin
            byte_stream.push_back(plain(SYNC_BYTE));
            pb = 8'($urandom_range(255));
            if (pb == SYNC_BYTE)
            begin
                pb = 8'h00;
            end
            byte_stream.push_back(plain(pb));
        end
        else
        begin
            kind = $urandom_range(99);
            if (kind < 2)
            begin
                len = $urandom_range(255, 200);
            end
            else if (kind < 12)
            begin
                len = $urandom_range(40, 9);
            end
            else
            begin
                len = $urandom_range(8, 0);
            end
            byte_stream.push_back(plain(SYNC_BYTE));
            byte_stream.push_back(plain(SYNC_BYTE));
            byte_stream.push_back(plain(len[7:0]));
            sum = len[7:0];
            for (int i = 0; i < len; i++)
            begin
                pb = 8'($urandom_range(255));
                sum = sum + pb;
                byte_stream.push_back(plain(pb));
            end
            // most checksums right, the rest random
            if ($urandom_range(99) < 80)
            begin
                byte_stream.push_back(plain(sum));
            end
            else
            begin
                byte_stream.push_back(plain(8'($urandom_range(255))));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // input side: offer bytes, hold them while stalled, idle at random
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_in
        stim_t   nxt;
        logic    got;
        result_t r;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                parse_byte(cur_row.b, got, r);
                if (got)
                begin
                    expected_frames.push_back(cur_row.typed ? cur_row.res : r);
                end
            end
            if (!in_valid || !in_stall)
            begin
                if (byte_stream.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt = byte_stream.pop_front();
                    cur_row  <= nxt;
                    rx_byte  <= nxt.b;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // output side: random stall plus one long hold-off, check each result
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : take_out
        result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_frames.size() == 0)
                begin
                    mismatches++;
                    $display("%0t unexpected result: len %h ok %b", $time,
                             payload_length, frame_ok);
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (frame_ok !== want.frame_ok)
                    begin
                        mismatches++;
                        $display("%0t frame_ok expected %b actual %b", $time,
                                 want.frame_ok, frame_ok);
                    end
                    if (payload_length !== want.payload_length)
                    begin
                        mismatches++;
                        $display("%0t payload_length expected %h actual %h", $time,
                                 want.payload_length, payload_length);
                    end
                    if (value_a !== want.value_a)
                    begin
                        mismatches++;
                        $display("%0t value_a expected %h actual %h", $time,
                                 want.value_a, value_a);
                    end
                    if (value_b !== want.value_b)
                    begin
                        mismatches++;
                        $display("%0t value_b expected %h actual %h", $time,
                                 want.value_b, value_b);
                    end
                    if (value_c !== want.value_c)
                    begin
                        mismatches++;
                        $display("%0t value_c expected %h actual %h", $time,
                                 want.value_c, value_c);
                    end
                end
            end
            out_stall <= hold_off || (!calm && $urandom_range(99) < IDLE_PCT);
        end
    end

    // long receiver hold-off so the result register fills and the input backs up
    initial
    begin
        wait (rst_n);
        repeat (900) @(posedge clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
    end

    // cycle count and run ceiling
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        shadow_reset();

        // directed rows: broken sync, zero-length frames, long frame with extreme values
        dir_table = '{
            // broken sync: lone byte, then sync followed by a non-sync byte
            plain(8'h55), plain(SYNC_BYTE), plain(8'h12),
            // zero length, checksum matches: held values stay at reset zero
            plain(SYNC_BYTE), plain(SYNC_BYTE), plain(8'h00),
            typed_row(8'h00, make_res(1'b1, 8'h00, 16'h0000, 16'h0000, 32'h0000_0000)),
            // zero length, wrong checksum: mismatch, values untouched
            plain(SYNC_BYTE), plain(SYNC_BYTE), plain(8'h00),
            typed_row(8'h01, make_res(1'b0, 8'h00, 16'h0000, 16'h0000, 32'h0000_0000)),
            // nine payload bytes: max value_a, min value_b, min value_c, ninth only summed
            plain(SYNC_BYTE), plain(SYNC_BYTE), plain(8'h09),
            plain(8'hFF), plain(8'hFF), plain(8'h80), plain(8'h00),
            plain(8'h80), plain(8'h00), plain(8'h00), plain(8'h00),
            plain(8'h01), plain(8'h08)
        };
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            byte_stream.push_back(dir_table[i]);
        end
        while (byte_stream.size() < DIR_ROWS + RANDOM_ITEMS)
        begin
            add_random_frame();
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // drain the stream, then every owed result, then a short tail for strays
        while (byte_stream.size() != 0 || in_valid)
        begin
            @(posedge clk);
        end
        while (expected_frames.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
